FILE: rtl/pvs_pkg.sv
// pvs_pkg: shared types, constants and helpers for the point Verlet step unit.
// No dependencies; imported by every module of the block.

package pvs_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DT_BITS   = 16;

   // fixed-point constants
   localparam logic signed [32:0] K09_Q = 33'(((9 << FRAC_BITS) + 5) / 10);
   localparam logic signed [32:0] K03_Q = 33'(((3 << FRAC_BITS) + 5) / 10);
   localparam logic signed [31:0] TOL_Q = 32'(((1 << FRAC_BITS) + 500) / 1000);
   localparam logic signed [65:0] ONE_Q = 66'(1 << FRAC_BITS);

   // divider geometry: 32-bit magnitude shifted up by the dt fraction
   localparam int DIV_W     = 32 + DT_BITS;
   localparam int DIV_CNT_W = $clog2(DIV_W + 1);

   // commands
   localparam logic [2:0] CMD_ADD_FORCE = 3'd0;
   localparam logic [2:0] CMD_STEP      = 3'd1;
   localparam logic [2:0] CMD_TELEPORT  = 3'd2;
   localparam logic [2:0] CMD_MOVE      = 3'd3;
   localparam logic [2:0] CMD_SET_POS   = 3'd4;

   // register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERSE_MASS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PINNED       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WALL_TOP     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WALL_BOTTOM  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WALL_LEFT    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_WALL_RIGHT   = 3'd5;

   typedef struct packed {
      logic [2:0]          command;
      logic signed [31:0]  vector_x;
      logic signed [31:0]  vector_y;
      logic [DT_BITS-1:0]  time_step;
   } req_type;

   typedef struct packed {
      logic signed [31:0] position_x;
      logic signed [31:0] position_y;
      logic signed [31:0] velocity_x;
      logic signed [31:0] velocity_y;
      logic               at_rest;
   } rsp_type;

   localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
   localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > SAT_MAX) begin
         r = 32'sh7fffffff;
      end else if (v < SAT_MIN) begin
         r = 32'sh80000000;
      end else begin
         r = 32'(v);
      end
      return r;
   endfunction

endpackage

FILE: rtl/pvs_mul.sv
// pvs_mul: shared 33x33 signed multiplier with a registered product.
// Depends on pvs_pkg.

module pvs_mul import pvs_pkg::*; (
   input  logic               clock,
   input  logic signed [32:0] op_a,
   input  logic signed [32:0] op_b,
   output logic signed [65:0] product
);

   logic signed [65:0] product_ff;
   logic signed [65:0] product_in;

   assign product_in = op_a * op_b;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

FILE: rtl/pvs_div.sv
// pvs_div: iterative unsigned restoring divider, one quotient bit per cycle.
// Depends on pvs_pkg for DIV_W; divisor is a 16-bit nonzero value.

module pvs_div import pvs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [DIV_W-1:0]    dividend,
   input  logic [DT_BITS-1:0]  divisor,
   output logic                done,
   output logic [DIV_W-1:0]    quotient
);

   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic                 done_ff, done_in;
   logic [DT_BITS-1:0]   rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DT_BITS-1:0]   dvs_ff, dvs_in;
   logic [DT_BITS:0]     trial;
   logic                 fits;

   always_comb begin
      trial    = {rem_ff, quo_ff[DIV_W-1]};
      fits     = trial >= {1'b0, dvs_ff};
      count_in = count_ff;
      done_in  = 1'b0;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      if (start) begin
         count_in = DIV_CNT_W'(DIV_W);
         rem_in   = '0;
         quo_in   = dividend;
         dvs_in   = divisor;
      end else if (count_ff != '0) begin
         count_in = count_ff - 1'b1;
         done_in  = (count_ff == DIV_CNT_W'(1));
         rem_in   = fits ? DT_BITS'(trial - {1'b0, dvs_ff}) : trial[DT_BITS-1:0];
         quo_in   = {quo_ff[DIV_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: rtl/point_verlet_step_unit.sv
// point_verlet_step_unit: one point mass with time-corrected Verlet steps.
// Depends on pvs_pkg, pvs_mul (shared multiplier) and pvs_div (shared divider).
//
//   channel | direction | handshake            | beat
//   req     | in        | req_valid/req_stall  | req_type: command, vector, time_step
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_type: position, velocity, at_rest
//   csr     | in        | csr_write            | csr_index, csr_data
//
// Non-step commands go from accept through ST_RESP, which registers the result.
// An unpinned step with nonzero time_step makes three divider runs (start, one
// bit step per quotient bit, done) for the step ratio and the x and y velocity,
// twelve issue-and-capture passes through the shared multiplier, and the sum,
// wall and response states. With no previous step the ratio divide is skipped.
// Synchronous active-high reset restores the power-up state of the control,
// configuration and point registers. req_stall is high whenever a command is in
// flight; a result held by rsp_stall holds the next command in ST_RESP.

module point_verlet_step_unit import pvs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [31:0]           csr_data
);

   localparam logic [4:0] ST_IDLE    = 5'd0;
   localparam logic [4:0] ST_M_DK    = 5'd1;
   localparam logic [4:0] ST_D_DELTA = 5'd2;
   localparam logic [4:0] ST_M_AX    = 5'd3;
   localparam logic [4:0] ST_M_AY    = 5'd4;
   localparam logic [4:0] ST_M_DT2   = 5'd5;
   localparam logic [4:0] ST_M_T1X   = 5'd6;
   localparam logic [4:0] ST_M_T1Y   = 5'd7;
   localparam logic [4:0] ST_M_T2X   = 5'd8;
   localparam logic [4:0] ST_M_T2Y   = 5'd9;
   localparam logic [4:0] ST_SUM     = 5'd10;
   localparam logic [4:0] ST_D_VX    = 5'd11;
   localparam logic [4:0] ST_D_VY    = 5'd12;
   localparam logic [4:0] ST_M_HX    = 5'd13;
   localparam logic [4:0] ST_M_HY    = 5'd14;
   localparam logic [4:0] ST_M_KX    = 5'd15;
   localparam logic [4:0] ST_M_KY    = 5'd16;
   localparam logic [4:0] ST_WALL    = 5'd17;
   localparam logic [4:0] ST_RESP    = 5'd18;

   // control
   logic [4:0] state_ff, state_in;
   logic       phase_ff, phase_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;

   // configuration
   logic [31:0]        inv_mass_ff, inv_mass_in;
   logic               pinned_ff, pinned_in;
   logic signed [31:0] wall_top_ff, wall_top_in;
   logic signed [31:0] wall_bottom_ff, wall_bottom_in;
   logic signed [31:0] wall_left_ff, wall_left_in;
   logic signed [31:0] wall_right_ff, wall_right_in;

   // point state
   logic signed [31:0]  pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic signed [31:0]  old_x_ff, old_x_in, old_y_ff, old_y_in;
   logic [DT_BITS-1:0]  last_step_ff, last_step_in;
   logic signed [31:0]  force_x_ff, force_x_in, force_y_ff, force_y_in;
   logic signed [31:0]  vel_x_ff, vel_x_in, vel_y_ff, vel_y_in;
   logic                rest_ff, rest_in;

   // step scratch
   logic [DT_BITS-1:0]  dt_ff, dt_in;
   logic [31:0]         numd_ff, numd_in;
   logic [31:0]         delta_ff, delta_in;
   logic signed [31:0]  accx_ff, accx_in, accy_ff, accy_in;
   logic [31:0]         dt2_ff, dt2_in;
   logic signed [31:0]  t1x_ff, t1x_in, t1y_ff, t1y_in;
   logic signed [31:0]  t2x_ff, t2x_in, t2y_ff, t2y_in;
   logic signed [31:0]  nx_ff, nx_in, ny_ff, ny_in;
   logic signed [31:0]  hx_ff, hx_in, hy_ff, hy_in;
   logic signed [31:0]  kx_ff, kx_in, ky_ff, ky_in;

   // shared units
   logic signed [32:0]  mul_a, mul_b;
   logic signed [65:0]  mul_p;
   logic                div_start, div_done;
   logic [DIV_W-1:0]    div_dividend, div_quotient;
   logic [DT_BITS-1:0]  div_divisor;

   // helpers
   logic                req_accept, rsp_take;
   logic signed [31:0]  dx, dy;
   logic signed [33:0]  diff_x, diff_y, diff_sel, diff_mag;
   logic                diff_neg;
   logic signed [65:0]  vel_q;
   logic signed [31:0]  wall_x;
   logic signed [31:0]  wy_old_x, wy_old_y, wy_pos_y;

   assign req_accept = req_valid && !req_stall;
   assign rsp_take   = rsp_valid_ff && !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   pvs_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_p)
   );

   pvs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign dx     = sat32(66'(pos_x_ff) - 66'(old_x_ff));
   assign dy     = sat32(66'(pos_y_ff) - 66'(old_y_ff));
   assign diff_x = 34'(nx_ff) - 34'(old_x_ff);
   assign diff_y = 34'(ny_ff) - 34'(old_y_ff);
   assign diff_sel = (state_ff == ST_D_VY) ? diff_y : diff_x;
   assign diff_neg = diff_sel[33];
   assign diff_mag = diff_neg ? -diff_sel : diff_sel;

   always_comb begin
      vel_q = $signed({{(66-DIV_W){1'b0}}, div_quotient});
      if (diff_neg) begin
         vel_q = -vel_q;
      end
   end

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_M_DK: begin
            mul_a = $signed({17'b0, dt_ff});
            mul_b = K09_Q;
         end
         ST_M_AX: begin
            mul_a = 33'(force_x_ff);
            mul_b = $signed({1'b0, inv_mass_ff});
         end
         ST_M_AY: begin
            mul_a = 33'(force_y_ff);
            mul_b = $signed({1'b0, inv_mass_ff});
         end
         ST_M_DT2: begin
            mul_a = $signed({17'b0, dt_ff});
            mul_b = $signed({17'b0, dt_ff});
         end
         ST_M_T1X: begin
            mul_a = 33'(dx);
            mul_b = $signed({1'b0, delta_ff});
         end
         ST_M_T1Y: begin
            mul_a = 33'(dy);
            mul_b = $signed({1'b0, delta_ff});
         end
         ST_M_T2X: begin
            mul_a = 33'(accx_ff);
            mul_b = $signed({1'b0, dt2_ff});
         end
         ST_M_T2Y: begin
            mul_a = 33'(accy_ff);
            mul_b = $signed({1'b0, dt2_ff});
         end
         ST_M_HX: begin
            mul_a = 33'(vel_x_ff);
            mul_b = $signed({17'b0, dt_ff});
         end
         ST_M_HY: begin
            mul_a = 33'(vel_y_ff);
            mul_b = $signed({17'b0, dt_ff});
         end
         ST_M_KX: begin
            mul_a = 33'(hx_ff);
            mul_b = K03_Q;
         end
         ST_M_KY: begin
            mul_a = 33'(hy_ff);
            mul_b = K03_Q;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // y wall first; its results feed the x wall
   always_comb begin
      wy_old_x = pos_x_ff;
      wy_old_y = pos_y_ff;
      wy_pos_y = ny_ff;
      if (ny_ff > wall_bottom_ff) begin
         wy_old_x = sat32(66'(nx_ff) - 66'(hx_ff >>> 1));
         wy_old_y = wall_bottom_ff;
         wy_pos_y = sat32(66'(wall_bottom_ff) - 66'(ky_ff));
      end else if (ny_ff < wall_top_ff) begin
         wy_old_y = sat32(66'(wall_top_ff) + ONE_Q);
         wy_pos_y = wy_old_y;
      end
      wall_x = (nx_ff > wall_right_ff) ? wall_right_ff : wall_left_ff;
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_take ? 1'b0 : rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      inv_mass_in    = inv_mass_ff;
      pinned_in      = pinned_ff;
      wall_top_in    = wall_top_ff;
      wall_bottom_in = wall_bottom_ff;
      wall_left_in   = wall_left_ff;
      wall_right_in  = wall_right_ff;

      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      old_x_in     = old_x_ff;
      old_y_in     = old_y_ff;
      last_step_in = last_step_ff;
      force_x_in   = force_x_ff;
      force_y_in   = force_y_ff;
      vel_x_in     = vel_x_ff;
      vel_y_in     = vel_y_ff;
      rest_in      = rest_ff;

      dt_in    = dt_ff;
      numd_in  = numd_ff;
      delta_in = delta_ff;
      accx_in  = accx_ff;
      accy_in  = accy_ff;
      dt2_in   = dt2_ff;
      t1x_in   = t1x_ff;
      t1y_in   = t1y_ff;
      t2x_in   = t2x_ff;
      t2y_in   = t2y_ff;
      nx_in    = nx_ff;
      ny_in    = ny_ff;
      hx_in    = hx_ff;
      hy_in    = hy_ff;
      kx_in    = kx_ff;
      ky_in    = ky_ff;

      div_start    = 1'b0;
      div_dividend = {diff_mag[31:0], {DT_BITS{1'b0}}};
      div_divisor  = dt_ff;

      if (csr_write) begin
         case (csr_index)
            CSR_INVERSE_MASS: inv_mass_in    = csr_data;
            CSR_PINNED:       pinned_in      = csr_data[0];
            CSR_WALL_TOP:     wall_top_in    = $signed(csr_data);
            CSR_WALL_BOTTOM:  wall_bottom_in = $signed(csr_data);
            CSR_WALL_LEFT:    wall_left_in   = $signed(csr_data);
            CSR_WALL_RIGHT:   wall_right_in  = $signed(csr_data);
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_RESP;
               case (req_data.command)
                  CMD_ADD_FORCE: begin
                     force_x_in = sat32(66'(force_x_ff) + 66'(req_data.vector_x));
                     force_y_in = sat32(66'(force_y_ff) + 66'(req_data.vector_y));
                  end
                  CMD_STEP: begin
                     dt_in = req_data.time_step;
                     if (!pinned_ff && req_data.time_step != '0) begin
                        state_in = ST_M_DK;
                     end
                  end
                  CMD_TELEPORT: begin
                     pos_x_in = req_data.vector_x;
                     pos_y_in = req_data.vector_y;
                     old_x_in = req_data.vector_x;
                     old_y_in = req_data.vector_y;
                     vel_x_in = '0;
                     vel_y_in = '0;
                     rest_in  = 1'b0;
                  end
                  CMD_MOVE: begin
                     if (!pinned_ff) begin
                        pos_x_in = sat32(66'(pos_x_ff) + 66'(req_data.vector_x));
                        pos_y_in = sat32(66'(pos_y_ff) + 66'(req_data.vector_y));
                     end
                  end
                  CMD_SET_POS: begin
                     pos_x_in = req_data.vector_x;
                     pos_y_in = req_data.vector_y;
                  end
                  default: ;
               endcase
            end
         end

         ST_D_DELTA: begin
            div_dividend = {{(DIV_W-32){1'b0}}, numd_ff};
            div_divisor  = last_step_ff;
            if (!phase_ff) begin
               if (last_step_ff == '0) begin
                  delta_in = 32'(K09_Q);
                  state_in = ST_M_AX;
               end else begin
                  div_start = 1'b1;
                  phase_in  = 1'b1;
               end
            end else if (div_done) begin
               delta_in = div_quotient[31:0];
               phase_in = 1'b0;
               state_in = ST_M_AX;
            end
         end

         ST_D_VX, ST_D_VY: begin
            if (!phase_ff) begin
               div_start = 1'b1;
               phase_in  = 1'b1;
            end else if (div_done) begin
               phase_in = 1'b0;
               if (state_ff == ST_D_VX) begin
                  vel_x_in = sat32(vel_q);
                  state_in = ST_D_VY;
               end else begin
                  vel_y_in = sat32(vel_q);
                  state_in = ST_M_HX;
               end
            end
         end

         ST_SUM: begin
            nx_in    = sat32(66'(pos_x_ff) + 66'(t1x_ff) + 66'(t2x_ff));
            ny_in    = sat32(66'(pos_y_ff) + 66'(t1y_ff) + 66'(t2y_ff));
            state_in = ST_D_VX;
         end

         ST_WALL: begin
            pos_x_in     = nx_ff;
            pos_y_in     = wy_pos_y;
            old_x_in     = wy_old_x;
            old_y_in     = wy_old_y;
            last_step_in = dt_ff;
            rest_in      = (vel_x_ff >= -TOL_Q) && (vel_x_ff <= TOL_Q) &&
                           (vel_y_ff >= -TOL_Q) && (vel_y_ff <= TOL_Q);
            if (nx_ff > wall_right_ff || nx_ff < wall_left_ff) begin
               old_y_in = sat32(66'(wy_pos_y) - 66'(hy_ff >>> 1));
               old_x_in = wall_x;
               pos_x_in = sat32(66'(wall_x) - 66'(kx_ff));
            end
            force_x_in = '0;
            force_y_in = '0;
            state_in   = ST_RESP;
         end

         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.position_x = pos_x_ff;
               rsp_data_in.position_y = pos_y_ff;
               rsp_data_in.velocity_x = vel_x_ff;
               rsp_data_in.velocity_y = vel_y_ff;
               rsp_data_in.at_rest    = rest_ff;
               state_in               = ST_IDLE;
            end
         end

         // multiplier passes: issue, then capture the registered product
         default: begin
            if (!phase_ff) begin
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               case (state_ff)
                  ST_M_DK: begin
                     numd_in  = mul_p[31:0];
                     state_in = ST_D_DELTA;
                  end
                  ST_M_AX: begin
                     accx_in  = sat32(mul_p >>> FRAC_BITS);
                     state_in = ST_M_AY;
                  end
                  ST_M_AY: begin
                     accy_in  = sat32(mul_p >>> FRAC_BITS);
                     state_in = ST_M_DT2;
                  end
                  ST_M_DT2: begin
                     dt2_in   = mul_p[31:0];
                     state_in = ST_M_T1X;
                  end
                  ST_M_T1X: begin
                     t1x_in   = sat32(mul_p >>> FRAC_BITS);
                     state_in = ST_M_T1Y;
                  end
                  ST_M_T1Y: begin
                     t1y_in   = sat32(mul_p >>> FRAC_BITS);
                     state_in = ST_M_T2X;
                  end
                  ST_M_T2X: begin
                     t2x_in   = 32'(mul_p >>> (2 * DT_BITS));
                     state_in = ST_M_T2Y;
                  end
                  ST_M_T2Y: begin
                     t2y_in   = 32'(mul_p >>> (2 * DT_BITS));
                     state_in = ST_SUM;
                  end
                  ST_M_HX: begin
                     hx_in    = 32'(mul_p >>> DT_BITS);
                     state_in = ST_M_HY;
                  end
                  ST_M_HY: begin
                     hy_in    = 32'(mul_p >>> DT_BITS);
                     state_in = ST_M_KX;
                  end
                  ST_M_KX: begin
                     kx_in    = 32'(mul_p >>> FRAC_BITS);
                     state_in = ST_M_KY;
                  end
                  ST_M_KY: begin
                     ky_in    = 32'(mul_p >>> FRAC_BITS);
                     state_in = ST_WALL;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         phase_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         inv_mass_ff    <= 32'd65536;
         pinned_ff      <= 1'b0;
         wall_top_ff    <= 32'sd0;
         wall_bottom_ff <= 32'sd39321600;
         wall_left_ff   <= 32'sd0;
         wall_right_ff  <= 32'sd52428800;
         pos_x_ff       <= '0;
         pos_y_ff       <= '0;
         old_x_ff       <= '0;
         old_y_ff       <= '0;
         last_step_ff   <= '0;
         force_x_ff     <= '0;
         force_y_ff     <= '0;
         vel_x_ff       <= '0;
         vel_y_ff       <= '0;
         rest_ff        <= 1'b0;
      end else begin
         state_ff       <= state_in;
         phase_ff       <= phase_in;
         rsp_valid_ff   <= rsp_valid_in;
         inv_mass_ff    <= inv_mass_in;
         pinned_ff      <= pinned_in;
         wall_top_ff    <= wall_top_in;
         wall_bottom_ff <= wall_bottom_in;
         wall_left_ff   <= wall_left_in;
         wall_right_ff  <= wall_right_in;
         pos_x_ff       <= pos_x_in;
         pos_y_ff       <= pos_y_in;
         old_x_ff       <= old_x_in;
         old_y_ff       <= old_y_in;
         last_step_ff   <= last_step_in;
         force_x_ff     <= force_x_in;
         force_y_ff     <= force_y_in;
         vel_x_ff       <= vel_x_in;
         vel_y_ff       <= vel_y_in;
         rest_ff        <= rest_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      dt_ff       <= dt_in;
      numd_ff     <= numd_in;
      delta_ff    <= delta_in;
      accx_ff     <= accx_in;
      accy_ff     <= accy_in;
      dt2_ff      <= dt2_in;
      t1x_ff      <= t1x_in;
      t1y_ff      <= t1y_in;
      t2x_ff      <= t2x_in;
      t2y_ff      <= t2y_in;
      nx_ff       <= nx_in;
      ny_ff       <= ny_in;
      hx_ff       <= hx_in;
      hy_ff       <= hy_in;
      kx_ff       <= kx_in;
      ky_ff       <= ky_in;
   end

`ifndef SYNTHESIS
   a_pinned_step_skips: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.command == CMD_STEP && pinned_ff) |=> state_ff == ST_RESP)
      else $error("pinned step entered the integration sequence");

   a_div_done_in_div_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> phase_ff && (state_ff == ST_D_DELTA || state_ff == ST_D_VX ||
                                state_ff == ST_D_VY))
      else $error("divider finished outside a divide pass");

   a_rest_means_slow: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && rest_ff) |->
         (vel_x_ff >= -TOL_Q && vel_x_ff <= TOL_Q &&
          vel_y_ff >= -TOL_Q && vel_y_ff <= TOL_Q))
      else $error("rest flag set with velocity above tolerance");
`endif

endmodule
